// ----- rtl/typed_array_packet_framer_unit_defines.svh -----
// Assertion macros shared by the framer modules.
// Both macros expect a clock named clk and an active-low reset named rst_n
// in the module where they are used.
`ifndef TYPED_ARRAY_PACKET_FRAMER_UNIT_DEFINES_SVH
`define TYPED_ARRAY_PACKET_FRAMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that holds in the same cycle.
`define TAPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in one cycle, consequent in the next cycle.
`define TAPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TAPF_ASSERT(lbl, prop)
`define TAPF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/tapf_pkg.sv -----
package tapf_pkg;

    // Input item kinds.
    typedef enum logic [0:0] {
        KIND_HEADER  = 1'b0,
        KIND_ELEMENT = 1'b1
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_WIDTH = 2'd1,
        STATUS_NO_FRAME  = 2'd2
    } status_t;

    // Framing constants.
    localparam logic [7:0] START_BYTE      = 8'h7B;
    localparam logic [7:0] STOP_BYTE       = 8'h7D;
    localparam int         SIGNED_FLAG_BIT = 5;
    localparam logic [7:0] MAX_ELEMENTS    = 8'd255;

    // Field widths.
    localparam int EBYTES_W   = 4;
    localparam int COUNT_W    = 8;
    localparam int VALUE_W    = 64;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_USER_W = 3;
    localparam int CMD_DATA_W = 72;
    localparam int NBYTES_W   = 4;

    // One queued command: up to nine bytes, sent lowest byte first.
    typedef struct packed {
        logic [CMD_DATA_W-1:0] data;
        logic [NBYTES_W-1:0]   nbytes;
        logic                  bvalid;
        status_t               status;
    } cmd_t;

endpackage

// ----- rtl/tapf_front.sv -----
`include "typed_array_packet_framer_unit_defines.svh"

module tapf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [tapf_pkg::EBYTES_W-1:0] elem_bytes,
    input  logic                          elem_signed,
    input  logic [tapf_pkg::COUNT_W-1:0]  count,
    input  logic [tapf_pkg::VALUE_W-1:0]  value,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tapf_pkg::cmd_t                push_cmd
);
    import tapf_pkg::*;

    logic                frame_open_reg, frame_open_next;
    logic [COUNT_W-1:0]  elements_left_reg, elements_left_next;
    logic [EBYTES_W-1:0] width_reg, width_next;
    logic                accept;
    logic [COUNT_W-1:0]  cnt_sat;
    logic [7:0]          flag;
    logic                stop;
    cmd_t                cmd;

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = in_valid;
    assign push_cmd   = cmd;

    // Classify the item, build its command and the next frame state.
    always_comb
    begin
        cmd                = '0;
        cmd.status         = STATUS_OK;
        frame_open_next    = frame_open_reg;
        elements_left_next = elements_left_reg;
        width_next         = width_reg;
        cnt_sat            = (count > MAX_ELEMENTS) ? MAX_ELEMENTS : count;
        flag               = 8'd1 << elem_bytes[3:1];
        flag[SIGNED_FLAG_BIT] = flag[SIGNED_FLAG_BIT] | elem_signed;
        stop               = 1'b0;
        if (kind_t'(kind) == KIND_HEADER)
        begin
            if (!(elem_bytes inside {4'd1, 4'd2, 4'd4, 4'd8}))
            begin
                cmd.nbytes = NBYTES_W'(1);
                cmd.status = STATUS_BAD_WIDTH;
            end
            else
            begin
                cmd.data   = {40'd0, STOP_BYTE, cnt_sat, flag, START_BYTE};
                cmd.bvalid = 1'b1;
                width_next = elem_bytes;
                if (cnt_sat == '0)
                begin
                    cmd.nbytes         = NBYTES_W'(4);
                    frame_open_next    = 1'b0;
                    elements_left_next = '0;
                end
                else
                begin
                    cmd.nbytes         = NBYTES_W'(3);
                    frame_open_next    = 1'b1;
                    elements_left_next = cnt_sat;
                end
            end
        end
        else
        begin
            if (!frame_open_reg)
            begin
                cmd.nbytes = NBYTES_W'(1);
                cmd.status = STATUS_NO_FRAME;
            end
            else
            begin
                elements_left_next = elements_left_reg - COUNT_W'(1);
                stop               = (elements_left_next == '0);
                frame_open_next    = !stop;
                cmd.bvalid         = 1'b1;
                cmd.data           = {8'd0, value};
                // Put the stop byte right after the element's last byte.
                case (width_reg)
                    4'd1:    cmd.data[15:8]  = STOP_BYTE;
                    4'd2:    cmd.data[23:16] = STOP_BYTE;
                    4'd4:    cmd.data[39:32] = STOP_BYTE;
                    default: cmd.data[71:64] = STOP_BYTE;
                endcase
                cmd.nbytes = width_reg + NBYTES_W'(stop);
            end
        end
    end

    // Frame state changes only when an item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg    <= 1'b0;
            elements_left_reg <= '0;
            width_reg         <= '0;
        end
        else if (accept)
        begin
            frame_open_reg    <= frame_open_next;
            elements_left_reg <= elements_left_next;
            width_reg         <= width_next;
        end
    end

    // An open frame always has elements to come and a legal width.
    `TAPF_ASSERT(a_open_has_elements, !frame_open_reg || (elements_left_reg != '0))
    `TAPF_ASSERT(a_open_width_legal, !frame_open_reg || (width_reg == 4'd1) ||
        (width_reg == 4'd2) || (width_reg == 4'd4) || (width_reg == 4'd8))

endmodule

// ----- rtl/tapf_fifo.sv -----
`include "typed_array_packet_framer_unit_defines.svh"

module tapf_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tapf_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_pop,
    output tapf_pkg::cmd_t out_cmd
);
    import tapf_pkg::*;

    cmd_t       mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // The fill level matches the pointer distance.
    `TAPF_ASSERT(a_fifo_ptrs, (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))

endmodule

// ----- rtl/tapf_back.sv -----
`include "typed_array_packet_framer_unit_defines.svh"

module tapf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  tapf_pkg::cmd_t cmd,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast
);
    import tapf_pkg::*;

    // Serializer working registers.
    logic                  busy_reg, busy_next;
    logic [CMD_DATA_W-1:0] shift_reg, shift_next;
    logic [NBYTES_W-1:0]   left_reg, left_next;
    logic                  bvalid_reg, bvalid_next;
    status_t               status_reg, status_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_byte_reg, m_byte_next;
    logic                  m_bvalid_reg, m_bvalid_next;
    status_t               m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_status_reg, m_bvalid_reg};
    assign m_tlast  = m_last_reg;

    // Emit one byte per cycle unless stalled, from work reg or queue head.
    always_comb
    begin
        busy_next     = busy_reg;
        shift_next    = shift_reg;
        left_next     = left_reg;
        bvalid_next   = bvalid_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_byte_next   = m_byte_reg;
        m_bvalid_next = m_bvalid_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        cmd_pop       = 1'b0;
        if (out_free)
        begin
            if (busy_reg)
            begin
                m_valid_next  = 1'b1;
                m_byte_next   = shift_reg[7:0];
                m_bvalid_next = bvalid_reg;
                m_status_next = status_reg;
                m_last_next   = (left_reg == NBYTES_W'(1));
                shift_next    = shift_reg >> 8;
                left_next     = left_reg - NBYTES_W'(1);
                busy_next     = (left_reg != NBYTES_W'(1));
            end
            else if (cmd_valid)
            begin
                cmd_pop       = 1'b1;
                m_valid_next  = 1'b1;
                m_byte_next   = cmd.data[7:0];
                m_bvalid_next = cmd.bvalid;
                m_status_next = cmd.status;
                m_last_next   = (cmd.nbytes == NBYTES_W'(1));
                shift_next    = cmd.data >> 8;
                left_next     = cmd.nbytes - NBYTES_W'(1);
                bvalid_next   = cmd.bvalid;
                status_next   = cmd.status;
                busy_next     = (cmd.nbytes != NBYTES_W'(1));
            end
            else
            begin
                m_valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bvalid_reg   <= bvalid_next;
        status_reg   <= status_next;
        m_byte_reg   <= m_byte_next;
        m_bvalid_reg <= m_bvalid_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    // A busy serializer has bytes left; error results are lone and empty.
    `TAPF_ASSERT(a_busy_has_bytes, !busy_reg || (left_reg != '0))
    `TAPF_ASSERT(a_error_result_form, !m_valid_reg || m_bvalid_reg ||
        (m_last_reg && (m_byte_reg == 8'd0) && (m_status_reg != STATUS_OK)))
    `TAPF_ASSERT_NEXT(a_stall_holds_work, m_valid_reg && !m_tready,
        $stable(left_reg) && $stable(busy_reg))

endmodule

// ----- rtl/typed_array_packet_framer_unit.sv -----
// Channel  | Direction | tdata                                        | tuser            | tlast
// s_axis   | in        | elem_bytes, elem_signed, count, value (80 b) | kind             | -
// m_axis   | out       | out_byte (8 b)                               | byte_valid,status| last
//
// A header sends 3 bytes (4 when the count is zero), an element sends its width
// in bytes plus a stop byte when it closes the frame, and an error sends 1.
// The back serializer sends one byte per cycle while m_tready allows; that sets the rate.
// A two-entry command queue sits between the front classifier and the serializer.
// Reset clears the frame state, the queue and the output register.
// Either side may stall at any time; the output register holds while m_tready is low.
`include "typed_array_packet_framer_unit_defines.svh"

module typed_array_packet_framer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // elem_bytes[3:0], elem_signed[4], count[12:5], value[76:13], zero pad
    input  logic [tapf_pkg::IN_DATA_W-1:0] s_tdata,
    // kind[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte[7:0]
    output logic [7:0]                     m_tdata,
    // byte_valid[0], status[2:1]
    output logic [tapf_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import tapf_pkg::*;

    logic                q_in_valid;
    logic                q_in_ready;
    cmd_t                q_in_cmd;
    logic                q_out_valid;
    logic                q_pop;
    cmd_t                q_out_cmd;
    logic [EBYTES_W-1:0] elem_bytes;
    logic                elem_signed;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  value;

    // Unpack the input item.
    assign elem_bytes  = s_tdata[3:0];
    assign elem_signed = s_tdata[4];
    assign count       = s_tdata[12:5];
    assign value       = s_tdata[76:13];

    // Front: accept and classify items.
    tapf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (s_tuser),
        .elem_bytes  (elem_bytes),
        .elem_signed (elem_signed),
        .count       (count),
        .value       (value),
        .push_valid  (q_in_valid),
        .push_ready  (q_in_ready),
        .push_cmd    (q_in_cmd)
    );

    // Command queue between front and back.
    tapf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_cmd    (q_in_cmd),
        .out_valid (q_out_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_out_cmd)
    );

    // Back: serialize commands into bytes.
    tapf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_out_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_out_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- dv/typed_array_packet_framer_unit_tb.sv -----
module typed_array_packet_framer_unit_tb;

    import tapf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS = 136;

    // One input item as the block sees it.
    typedef struct {
        kind_t       kind;
        logic [3:0]  elem_bytes;
        logic        elem_signed;
        logic [7:0]  count;
        logic [63:0] value;
    } framer_item_t;

    // One output byte slot with its side flags.
    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_flag;
        status_t    status;
    } framer_byte_t;

    // Tracks the framing state and holds the bytes still to come.
    class framer_scoreboard;
        framer_byte_t expected_bytes[$];
        bit           frame_open;
        logic [7:0]   elements_left;
        logic [3:0]   width_in_use;
        int           mismatches;

        function void push_byte(input logic [7:0] b, input logic v, input status_t st);
            framer_byte_t r;
            r.out_byte   = b;
            r.byte_valid = v;
            r.last_flag  = 1'b0;
            r.status     = st;
            expected_bytes.push_back(r);
        endfunction

        // Works out the bytes that one accepted item causes.
        function void add_item(input framer_item_t it);
            logic [7:0]   flag;
            logic [7:0]   cnt;
            logic [63:0]  word;
            int           w;
            int           first;
            framer_byte_t tail;
            first = expected_bytes.size();
            if (it.kind == KIND_HEADER)
            begin
                if (!(it.elem_bytes inside {4'd1, 4'd2, 4'd4, 4'd8}))
                begin
                    push_byte(8'h00, 1'b0, STATUS_BAD_WIDTH);
                end
                else
                begin
                    cnt = (it.count > MAX_ELEMENTS) ? MAX_ELEMENTS : it.count;
                    flag = 8'd1 << (it.elem_bytes / 2);
                    if (it.elem_signed)
                        flag[SIGNED_FLAG_BIT] = 1'b1;
                    push_byte(START_BYTE, 1'b1, STATUS_OK);
                    push_byte(flag, 1'b1, STATUS_OK);
                    push_byte(cnt, 1'b1, STATUS_OK);
                    width_in_use = it.elem_bytes;
                    if (cnt == 8'd0)
                    begin
                        push_byte(STOP_BYTE, 1'b1, STATUS_OK);
                        frame_open    = 1'b0;
                        elements_left = 8'd0;
                    end
                    else
                    begin
                        frame_open    = 1'b1;
                        elements_left = cnt;
                    end
                end
            end
            else if (!frame_open)
            begin
                push_byte(8'h00, 1'b0, STATUS_NO_FRAME);
            end
            else
            begin
                w = (width_in_use > 4'd8) ? 8 : int'(width_in_use);
                word = it.value;
                for (int i = 0; i < w; i++)
                begin
                    push_byte(word[7:0], 1'b1, STATUS_OK);
                    word = word >> 8;
                end
                if (elements_left > 8'd0)
                    elements_left = elements_left - 8'd1;
                if (elements_left == 8'd0)
                begin
                    push_byte(STOP_BYTE, 1'b1, STATUS_OK);
                    frame_open = 1'b0;
                end
                if (expected_bytes.size() == first)
                    push_byte(8'h00, 1'b0, STATUS_OK);
            end
            // The final byte of the run carries the last mark.
            tail = expected_bytes.pop_back();
            tail.last_flag = 1'b1;
            expected_bytes.push_back(tail);
        endfunction

        function void check_field(input string name, input logic [7:0] exp_v,
                                  input logic [7:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // Compares one accepted output item with the oldest expected byte.
        function void check_byte(input framer_byte_t got);
            framer_byte_t exp_b;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output, expected none, actual byte %0h last %0b",
                         $time, got.out_byte, got.last_flag);
                mismatches++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            check_field("out_byte", exp_b.out_byte, got.out_byte);
            check_field("byte_valid", 8'(exp_b.byte_valid), 8'(got.byte_valid));
            check_field("last", 8'(exp_b.last_flag), 8'(got.last_flag));
            check_field("status", 8'(exp_b.status), 8'(got.status));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   m_tlast;

    framer_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  items_sent;
    int  quiet_cycles;
    bit  hold_request;

    typed_array_packet_framer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one item, with a random gap in front, and waits for acceptance.
    task automatic send_item(input framer_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b000, it.value, it.count, it.elem_signed, it.elem_bytes};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.add_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic framer_item_t rand_item(input kind_t k);
        framer_item_t it;
        it.kind        = k;
        it.elem_bytes  = 4'($urandom_range(15));
        it.elem_signed = 1'($urandom_range(1));
        it.count       = 8'($urandom_range(255));
        it.value       = {$urandom, $urandom};
        return it;
    endfunction

    task automatic send_header(input logic [3:0] eb, input logic sgn, input logic [7:0] cnt);
        framer_item_t it;
        it = rand_item(KIND_HEADER);
        it.elem_bytes  = eb;
        it.elem_signed = sgn;
        it.count       = cnt;
        send_item(it);
    endtask

    task automatic send_element(input logic [63:0] val);
        framer_item_t it;
        it = rand_item(KIND_ELEMENT);
        it.value = val;
        send_item(it);
    endtask

    // Field extremes and the special cases of the framing rules.
    task automatic run_directed();
        send_element(64'hFFFF_FFFF_FFFF_FFFF);       // element with no frame open
        send_header(4'd0, 1'b0, 8'd3);               // bad widths
        send_header(4'd15, 1'b1, 8'd255);
        send_header(4'd3, 1'b0, 8'd1);
        send_element(64'h0);                         // still no frame after a bad width
        send_header(4'd1, 1'b1, 8'd0);               // empty frame
        send_header(4'd8, 1'b0, 8'd2);
        send_element(64'hFFFF_FFFF_FFFF_FFFF);
        send_element(64'h0123_4567_89AB_CDEF);
        send_element(64'h0);                         // frame already closed
        send_header(4'd2, 1'b1, 8'd1);
        send_element(64'h0000_0000_0000_8001);
        send_header(4'd4, 1'b0, 8'd3);
        send_element(64'hDEAD_BEEF_CAFE_F00D);
        send_header(4'd1, 1'b0, 8'd255);             // abandons the open frame
        send_element(64'hFFFF_FFFF_FFFF_FF7D);
        send_element(64'h0);
        send_header(4'd8, 1'b1, 8'd255);
        send_header(4'd1, 1'b0, 8'd1);
        send_element(64'h0000_0000_0000_007B);
        send_element(64'h5555_5555_5555_5555);       // no frame again
        send_header(4'd4, 1'b1, 8'd0);
    endtask

    // Mostly complete frames with random content, mixed with broken ones.
    task automatic run_random(input int n);
        int          stop_at;
        int          r;
        int          n_el;
        logic [3:0]  eb;
        logic [7:0]  cnt;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                case ($urandom_range(3))
                    0: eb = 4'd1;
                    1: eb = 4'd2;
                    2: eb = 4'd4;
                    default: eb = 4'd8;
                endcase
                if ($urandom_range(9) == 0)
                    cnt = 8'($urandom_range(255));
                else
                    cnt = 8'($urandom_range(6));
                send_header(eb, 1'($urandom_range(1)), cnt);
                n_el = (cnt > 8'd6) ? $urandom_range(1, 8) : int'(cnt);
                if ($urandom_range(9) == 0)
                    n_el = $urandom_range(0, n_el);
                for (int i = 0; i < n_el; i++)
                    send_element({$urandom, $urandom});
            end
            else if (r < 88)
            begin
                do
                    eb = 4'($urandom_range(15));
                while (eb inside {4'd1, 4'd2, 4'd4, 4'd8});
                send_header(eb, 1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            else if (r < 95)
            begin
                send_element({$urandom, $urandom});
            end
            else
            begin
                send_item(rand_item(kind_t'($urandom_range(1))));
            end
        end
    endtask

    // Receiver: random ready, with one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output checking at the rising edge.
    always @(posedge clk)
    begin
        framer_byte_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.out_byte   = m_tdata;
            got.byte_valid = m_tuser[0];
            got.last_flag  = m_tlast;
            got.status     = status_t'(m_tuser[2:1]);
            sb.check_byte(got);
        end
    end

    // Watchdog on cycles where neither side moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        sb = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 82;
        items_sent    = 0;
        quiet_cycles  = 0;
        hold_request  = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(PHASE_ITEMS);

        send_idle_pct = 82;
        recv_idle_pct = 34;
        run_random(PHASE_ITEMS);

        // No idling; the receiver stalls long once so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        run_random(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tapf_pkg.sv
rtl/tapf_front.sv
rtl/tapf_fifo.sv
rtl/tapf_back.sv
rtl/typed_array_packet_framer_unit.sv
dv/typed_array_packet_framer_unit_tb.sv
